FILE: hdl/silu_pwl_pkg.sv
`timescale 1ns / 1ps

package silu_pwl_pkg;

  // Sample and result width, Q5.10 by default
  localparam int DataW = 16;

  // Default number of fractional bits
  localparam int FractionBitsDefault = 10;

  // Grid: 21 points from -5 to +5 in steps of 0.5, 20 segments
  localparam int GridPoints = 21;
  localparam int Segments   = GridPoints - 1;
  localparam int IdxW       = $clog2(Segments);

  // Fractional bits of the master table
  localparam int MasterBits = 20;

  // SiLU at x = -5 + 0.5*i, scaled by 2^20 and rounded
  localparam int SiluMaster [GridPoints] = '{
    -35090, -51843, -75440, -107576, -149189, -198858, -249987,
    -286931, -282006, -197940, 0,
    326348, 766570, 1285933, 1847165, 2422582, 2996539, 3562440,
    4118864, 4666749, 5207790
  };

  // Grid value i rounded to frac_bits fractional bits, ties toward plus infinity
  function automatic int rom_value(input int i, input int frac_bits);
    int m;
    int drop;
    drop = MasterBits - frac_bits;
    m = SiluMaster[i];
    return (m + (1 << (drop - 1))) >>> drop;
  endfunction

  // Slope of segment i, as the difference of the rounded grid values
  function automatic int rom_diff(input int i, input int frac_bits);
    return rom_value(i + 1, frac_bits) - rom_value(i, frac_bits);
  endfunction

endpackage

FILE: hdl/silu_pwl_interp.sv
`timescale 1ns / 1ps

module silu_pwl_interp #(
  parameter int FractionBits = silu_pwl_pkg::FractionBitsDefault
) (
  input  logic signed [silu_pwl_pkg::DataW-1:0] x_i,
  output logic signed [silu_pwl_pkg::DataW-1:0] y_o
);

  localparam int DataW = silu_pwl_pkg::DataW;
  localparam int IdxW  = silu_pwl_pkg::IdxW;
  localparam int SumW  = DataW + 2;
  localparam int OffW  = IdxW + FractionBits - 1;
  localparam int FracW = FractionBits - 1;
  localparam int ProdW = FracW + DataW + 1;
  localparam int Limit = 5 << FractionBits;

  logic signed [SumW-1:0]  x_ext;
  logic signed [SumW-1:0]  off_full;
  logic                    sat_low;
  logic                    sat_high;
  logic [OffW-1:0]         off;
  logic [IdxW-1:0]         idx;
  logic [FracW-1:0]        frac;
  logic signed [DataW-1:0] base;
  logic signed [DataW-1:0] diff;
  logic signed [FracW:0]   frac_s;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [ProdW-1:0] step;
  logic signed [DataW-1:0] interp;

  // Shift the sample onto the grid and detect both ends
  assign x_ext    = SumW'(x_i);
  assign off_full = x_ext + SumW'(Limit);
  assign sat_low  = (x_ext <= -SumW'(Limit));
  assign sat_high = (x_ext >= SumW'(Limit));

  // Split the offset into segment index and fraction
  assign off  = off_full[OffW-1:0];
  assign idx  = off[OffW-1:FracW];
  assign frac = off[FracW-1:0];

  // Look up the left grid value and the segment slope
  assign base = DataW'(silu_pwl_pkg::rom_value(int'(idx), FractionBits));
  assign diff = DataW'(silu_pwl_pkg::rom_diff(int'(idx), FractionBits));

  // Interpolate and round to nearest, ties toward plus infinity
  assign frac_s   = {1'b0, frac};
  assign prod     = ProdW'(frac_s) * ProdW'(diff);
  assign prod_rnd = prod + (ProdW'(1) <<< (FracW - 1));
  assign step     = prod_rnd >>> FracW;
  assign interp   = base + DataW'(step);

  // Pick zero, pass-through or the interpolated value
  always_comb begin
    if (sat_low) begin
      y_o = '0;
    end else if (sat_high) begin
      y_o = x_i;
    end else begin
      y_o = interp;
    end
  end

endmodule

FILE: hdl/silu_piecewise_linear_lut.sv
`timescale 1ns / 1ps

// SiLU activation, x*sigmoid(x), by linear interpolation over a 21-point grid from
// -5 to +5 in steps of 0.5, on signed fixed-point samples with FractionBits
// fractional bits (Q5.10 by default) in and out. Inputs at or below -5 give 0,
// inputs at or above +5 pass through unchanged. The block takes one item per
// clock while its output is not stalled. One register holds the accepted sample,
// the table lookup and one multiply-add run between it and the result register.
// The result register lets a new item in while a finished one waits on a
// stalled output.
module silu_piecewise_linear_lut #(
  parameter int FractionBits = silu_pwl_pkg::FractionBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [silu_pwl_pkg::DataW-1:0] sample_in_i,
  input  logic                                  sample_valid_i,
  output logic                                  sample_stall_o,
  output logic signed [silu_pwl_pkg::DataW-1:0] activation_out_o,
  output logic                                  activation_valid_o,
  input  logic                                  activation_stall_i
);

  localparam int DataW = silu_pwl_pkg::DataW;

  logic                    in_valid_q;
  logic                    in_valid_d;
  logic signed [DataW-1:0] in_sample_q;
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic signed [DataW-1:0] out_act_q;
  logic signed [DataW-1:0] result;
  logic                    advance;
  logic                    in_accept;

  // Move the held item on when the result register is free or being emptied
  assign advance        = !out_valid_q || !activation_stall_i;
  assign sample_stall_o = in_valid_q && !advance;
  assign in_accept      = sample_valid_i && !sample_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the accepted sample
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_sample_q <= sample_in_i;
    end
  end

  silu_pwl_interp #(
    .FractionBits(FractionBits)
  ) u_interp (
    .x_i(in_sample_q),
    .y_o(result)
  );

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_act_q <= result;
    end
  end

  assign activation_out_o   = out_act_q;
  assign activation_valid_o = out_valid_q;

endmodule

FILE: hdl/silu_pwl_checker.sv
`timescale 1ns / 1ps

module silu_pwl_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  sample_valid_i,
  input logic                                  sample_stall_o,
  input logic signed [silu_pwl_pkg::DataW-1:0] activation_out_o,
  input logic                                  activation_valid_o,
  input logic                                  activation_stall_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    activation_valid_o && activation_stall_i |=> activation_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    activation_valid_o && activation_stall_i |=> $stable(activation_out_o))
    else $error("result changed while stalled");

  // Input stalls only when a result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_stall_o |-> activation_valid_o && activation_stall_i)
    else $error("input stalled without output backpressure");

  // An accepted item, followed by an open output, leaves a valid result on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_valid_i && !sample_stall_o) ##1 !activation_stall_i |=> activation_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind silu_piecewise_linear_lut silu_pwl_checker u_checker (.*);

FILE: tb/silu_piecewise_linear_lut_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the SiLU block, predicts each result from the accepted
// sample and compares it with the result that leaves the block, in order.
module silu_piecewise_linear_lut_checker #(
  parameter int FracBits = silu_pwl_pkg::FractionBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [silu_pwl_pkg::DataW-1:0] sample_in_i,
  input  logic                                  sample_valid_i,
  input  logic                                  sample_stall_i,
  input  logic signed [silu_pwl_pkg::DataW-1:0] activation_out_i,
  input  logic                                  activation_valid_i,
  input  logic                                  activation_stall_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  localparam int W        = silu_pwl_pkg::DataW;
  localparam int GridQ    = 20;
  localparam int SegShift = FracBits - 1;

  // SiLU at x = -5, -4.5, ..., +5, scaled by 2^20
  localparam int GridSiluQ20 [21] = '{
    -35090, -51843, -75440, -107576, -149189, -198858, -249987,
    -286931, -282006, -197940, 0,
    326348, 766570, 1285933, 1847165, 2422582, 2996539, 3562440,
    4118864, 4666749, 5207790
  };

  logic signed [W-1:0] expected_activations [$];
  int                  mismatches = 0;

  // Round grid point i down to FracBits fraction bits, ties toward plus infinity
  function automatic int grid_value(input int i);
    int drop;
    drop = GridQ - FracBits;
    return (GridSiluQ20[i] + (1 << (drop - 1))) >>> drop;
  endfunction

  // Interpolate SiLU between the two grid points around x; 0 at or below -5, x at or above +5
  function automatic logic signed [W-1:0] silu_interp(input logic signed [W-1:0] x);
    int xi;
    int lim;
    int off;
    int seg;
    int frac;
    int base;
    int slope;
    int prod;
    xi  = x;
    lim = 5 << FracBits;
    if (xi <= -lim) return '0;
    if (xi >= lim) return x;
    off   = xi + lim;
    seg   = off >>> SegShift;
    frac  = off & ((1 << SegShift) - 1);
    base  = grid_value(seg);
    slope = grid_value(seg + 1) - base;
    prod  = frac * slope + (1 << (SegShift - 1));
    return W'(base + (prod >>> SegShift));
  endfunction

  // Queue a prediction per accepted sample, check each accepted result
  always @(posedge clk_i) begin
    logic signed [W-1:0] want;
    if (rst_ni) begin
      if (sample_valid_i && !sample_stall_i) begin
        expected_activations.push_back(silu_interp(sample_in_i));
      end
      if (activation_valid_i && !activation_stall_i) begin
        if (expected_activations.size() == 0) begin
          $error("activation_out: item with no expected value, actual %0d",
                 activation_out_i);
          mismatches++;
        end else begin
          want = expected_activations.pop_front();
          if (activation_out_i !== want) begin
            $error("activation_out mismatch: expected %0d, actual %0d",
                   want, activation_out_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_activations.size();
  end

endmodule

FILE: tb/silu_piecewise_linear_lut_tb.sv
`timescale 1ns / 1ps

module silu_piecewise_linear_lut_tb;

  localparam int W            = silu_pwl_pkg::DataW;
  localparam int PhaseItems   = 160;
  localparam int HoldItems    = 30;
  localparam int HoldCycles   = 80;
  localparam int DrainCycles  = 10;
  localparam int CycleLimit   = 200000;

  // Grid ends, exact grid points, rounding ties, widest fractions, range ends
  localparam int CornerSamples [20] = '{
    -32768, 32767, -32767, -5120, -5119, -5121, 5120, 5119, 5121, 0,
    -1, 1, -4864, -4609, -4608, 512, 256, 4864, 16384, -16384
  };

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic signed [W-1:0] sample_in          = '0;
  logic                sample_valid       = 1'b0;
  logic                sample_stall;
  logic signed [W-1:0] activation_out;
  logic                activation_valid;
  logic                activation_stall   = 1'b0;

  int fail_count;
  int pending;
  int offer_gap_pct = 0;
  int stall_pct     = 0;
  int hold_trigger  = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  silu_piecewise_linear_lut DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .sample_in_i        (sample_in),
    .sample_valid_i     (sample_valid),
    .sample_stall_o     (sample_stall),
    .activation_out_o   (activation_out),
    .activation_valid_o (activation_valid),
    .activation_stall_i (activation_stall)
  );

  silu_piecewise_linear_lut_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .sample_in_i        (sample_in),
    .sample_valid_i     (sample_valid),
    .sample_stall_i     (sample_stall),
    .activation_out_i   (activation_out),
    .activation_valid_i (activation_valid),
    .activation_stall_i (activation_stall),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Stall the result side at random, or hold it off for a long stretch on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      activation_stall <= 1'b1;
      hold_left--;
    end else if (hold_trigger != hold_taken) begin
      hold_taken = hold_trigger;
      hold_left  = HoldCycles - 1;
      activation_stall <= 1'b1;
    end else begin
      activation_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one sample after a random gap and hold it until accepted
  task automatic offer_sample(input logic signed [W-1:0] value);
    while ($urandom_range(99) < offer_gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_in    <= value;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has left the block
  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly the interpolated band, some near the grid ends, some anywhere
  function automatic logic signed [W-1:0] random_sample();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 70) begin
      v = int'($urandom_range(10400)) - 5200;
    end else if (pick < 85) begin
      v = 5120 + int'($urandom_range(16)) - 8;
      if ($urandom_range(1)) v = -v;
    end else begin
      v = $urandom;
    end
    return W'(v);
  endfunction

  // Run the random part under one idling setting, then drain
  task automatic run_phase(input int gap_pct, input int stall_pct_in);
    offer_gap_pct = gap_pct;
    stall_pct    <= stall_pct_in;
    for (int n = 0; n < PhaseItems; n++) begin
      offer_sample(random_sample());
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners, no idling
    foreach (CornerSamples[k]) begin
      offer_sample(W'(CornerSamples[k]));
    end
    drain_results();

    run_phase(0, 0);
    run_phase(60, 0);
    run_phase(0, 60);
    run_phase(21, 21);

    // Hold the result side off while items keep coming, so the input stalls
    offer_gap_pct = 0;
    stall_pct    <= 0;
    hold_trigger <= hold_trigger + 1;
    for (int n = 0; n < HoldItems; n++) begin
      offer_sample(random_sample());
    end
    drain_results();

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: silu_piecewise_linear_lut.f
hdl/silu_pwl_pkg.sv
hdl/silu_pwl_interp.sv
hdl/silu_piecewise_linear_lut.sv
hdl/silu_pwl_checker.sv
tb/silu_piecewise_linear_lut_checker.sv
tb/silu_piecewise_linear_lut_tb.sv
